/* design/mcu8_pkg.sv */
// Shared constants and types for the 8-bit accumulator ALU core.
`default_nettype none
package mcu8_pkg;
   localparam logic [5:0] FN_ADD = 6'd0, FN_ADC = 6'd1, FN_SUB = 6'd2, FN_SBC = 6'd3,
      FN_CMP = 6'd4, FN_CPX = 6'd5, FN_AND = 6'd6, FN_BIT = 6'd7, FN_ORA = 6'd8,
      FN_EOR = 6'd9, FN_LDA = 6'd10, FN_LDX = 6'd11, FN_STA = 6'd12, FN_STX = 6'd13,
      FN_ASR = 6'd14, FN_LSR = 6'd15, FN_ROR = 6'd16, FN_LSL = 6'd17, FN_ROL = 6'd18,
      FN_INC = 6'd19, FN_DEC = 6'd20, FN_NEG = 6'd21, FN_COM = 6'd22, FN_CLR = 6'd23,
      FN_TST = 6'd24, FN_DAA = 6'd25, FN_MUL = 6'd26, FN_DIV = 6'd27, FN_NSA = 6'd28,
      FN_TAX = 6'd29, FN_TXA = 6'd30, FN_TAP = 6'd31, FN_TPA = 6'd32, FN_CLC = 6'd33,
      FN_SEC = 6'd34, FN_CLI = 6'd35, FN_SEI = 6'd36, FN_CPHX = 6'd37, FN_LDHX = 6'd38,
      FN_BSET = 6'd39, FN_BCLR = 6'd40, FN_BRSET = 6'd41, FN_BRCLR = 6'd42,
      FN_CBEQ = 6'd43, FN_DBNZ = 6'd44, FN_BCC = 6'd45, FN_MOV = 6'd47;

   localparam logic [1:0] TGT_MEM = 2'd0, TGT_A = 2'd1, TGT_X = 2'd2, TGT_H = 2'd3;

   localparam int FL_C = 0, FL_Z = 1, FL_N = 2, FL_I = 3, FL_H = 4, FL_V = 7;
   localparam logic [7:0] FLAG_MASK  = 8'h9F;
   localparam logic [7:0] FLAG_RESET = 8'h08;

   // divider step count: one quotient bit per cycle
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // start request and result of the shared divide/multiply unit
   typedef struct packed {
      logic       start;
      logic       is_mul;
      logic [15:0] dividend;
      logic [7:0] divisor;
   } mcu8_seq_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quot;
      logic [7:0]  rem;
   } mcu8_seq_res_type;
endpackage
`default_nettype wire

/* design/mcu8_iter.sv */
// Shared shift-and-add unit: 16-step restoring divide or 8-step multiply.
`default_nettype none
module mcu8_iter
   import mcu8_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mcu8_seq_cmd_type cmd,
   output mcu8_seq_res_type      res
);
   logic                 busy_ff, busy_in;
   logic                 mul_ff, mul_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          q_ff, q_in;
   logic [8:0]           r_ff, r_in;
   logic [7:0]           d_ff, d_in;
   logic [8:0]           trial;
   logic [8:0]           sum;

   always_comb begin
      busy_in = busy_ff;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      trial   = {r_ff[7:0], q_ff[15]};
      sum     = {1'b0, r_ff[7:0]} + {1'b0, (q_ff[0] ? d_ff : 8'h00)};
      if (cmd.start) begin
         busy_in = 1'b1;
         mul_in  = cmd.is_mul;
         cnt_in  = '0;
         q_in    = cmd.dividend;
         r_in    = '0;
         d_in    = cmd.divisor;
      end else if (busy_ff) begin
         if (mul_ff) begin
            // q[7:0] multiplier, result high in r, low shifts into q[15:8]
            r_in = {1'b0, sum[8:1]};
            q_in = {sum[0], q_ff[15:8], q_ff[7:1]};
            if (cnt_ff == DIV_CNT_W'(7)) busy_in = 1'b0;
         end else begin
            if (r_ff[8] || trial >= {1'b0, d_ff}) begin
               r_in = {1'b0, trial[7:0] - d_ff};
               q_in = {q_ff[14:0], 1'b1};
            end else begin
               r_in = trial;
               q_in = {q_ff[14:0], 1'b0};
            end
            if (r_ff[7] && !(r_ff[8])) r_in = {1'b0, 8'(trial - {1'b0, d_ff})};
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) busy_in = 1'b0;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // remainder can reach 9 bits before subtraction; handled via trial width
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mul_ff <= mul_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   always_comb begin
      res.done = busy_ff && !busy_in;
      res.quot = q_in;
      res.rem  = mul_ff ? r_in[7:0] : r_in[7:0];
   end
endmodule
`default_nettype wire

/* design/mcu8_alu_with_condition_codes_core.sv */
// Top level: register file, combinational ALU decode and a sequencer around the shared unit.
// Flow: an accepted request is latched, then ST_EXEC registers the result for most operations
// and for divide by zero; MUL/DIV wait in ST_WAIT while the shared unit does one shift/add step per cycle.
// Throughput: one transaction at a time; a new one is accepted once the result is taken
// or while the result register is being emptied in the same cycle.
// Reset: synchronous, active high; A, H, X clear, flags = I set, no result pending.
`default_nettype none
module mcu8_alu_with_condition_codes_core
   import mcu8_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [5:0] req_func,
   input  wire logic [7:0] req_operand,
   input  wire logic [7:0] req_operand_high,
   input  wire logic [1:0] req_target,
   input  wire logic [2:0] req_bit_index,
   input  wire logic [4:0] req_condition,
   input  wire logic       req_irq_level,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_write_data,
   output logic            rsp_write_enable,
   output logic            rsp_branch_taken,
   output logic [7:0]      rsp_acc_out,
   output logic [7:0]      rsp_index_high_out,
   output logic [7:0]      rsp_index_low_out,
   output logic [7:0]      rsp_flags_out
);
   localparam logic [1:0] ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_WAIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [7:0] a_ff, a_in, h_ff, h_in, x_ff, x_in, f_ff, f_in;
   logic       out_v_ff, out_v_in;
   logic [7:0] wd_ff, wd_in;
   logic       we_ff, we_in, br_ff, br_in;
   // latched transaction
   logic [5:0] fn_ff;
   logic [7:0] m_ff, mh_ff;
   logic [1:0] tg_ff;
   logic [2:0] bi_ff;
   logic [4:0] cn_ff;
   logic       irq_ff;

   mcu8_seq_cmd_type cmd;
   mcu8_seq_res_type res;

   mcu8_iter u_iter (.clock(clock), .reset(reset), .cmd(cmd), .res(res));

   logic       accept;
   logic [7:0] src, r8;
   logic [8:0] s9;
   logic [4:0] hs;
   logic [3:0] hi4, lo4;
   logic [7:0] fix;
   logic [15:0] hx, mw, t16;
   logic       cin, cr, sh_c, cu;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!out_v_ff || rsp_ready);

   function automatic logic cond_eval(input logic [4:0] c, input logic [7:0] f, input logic irq);
      logic r;
      case (c[4:1])
         4'd0: r = 1'b1;
         4'd1: r = !(f[FL_C] || f[FL_Z]);
         4'd2: r = !f[FL_C];
         4'd3: r = !f[FL_Z];
         4'd4: r = !f[FL_H];
         4'd5: r = !f[FL_N];
         4'd6: r = !f[FL_I];
         4'd7: r = !irq;
         4'd8: r = !(f[FL_N] ^ f[FL_V]);
         4'd9: r = !(f[FL_Z] || (f[FL_N] ^ f[FL_V]));
         default: r = 1'b0;
      endcase
      if (c[4:1] > 4'd9) cond_eval = 1'b0;
      else cond_eval = c[0] ? !r : r;
   endfunction

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; h_in = h_ff; x_in = x_ff; f_in = f_ff;
      out_v_in = out_v_ff; wd_in = wd_ff; we_in = we_ff; br_in = br_ff;
      cmd = '0;
      cmd.dividend = {h_ff, a_ff};
      cmd.divisor  = x_ff;
      case (tg_ff)
         TGT_A:   src = a_ff;
         TGT_X:   src = x_ff;
         TGT_H:   src = h_ff;
         default: src = m_ff;
      endcase
      r8 = 8'h00; s9 = '0; hs = '0; cin = 1'b0; cr = 1'b0; sh_c = 1'b0;
      hi4 = a_ff[7:4]; lo4 = a_ff[3:0]; fix = 8'h00; cu = 1'b0;
      hx = {h_ff, x_ff}; mw = {mh_ff, m_ff}; t16 = hx - mw;

      if (out_v_ff && rsp_ready) out_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            wd_in = 8'h00; we_in = 1'b0; br_in = 1'b0;
            state_in = ST_IDLE; out_v_in = 1'b1;
            case (fn_ff)
               FN_ADD, FN_ADC: begin
                  cin = (fn_ff == FN_ADC) && f_ff[FL_C];
                  s9 = {1'b0, a_ff} + {1'b0, m_ff} + {8'h00, cin};
                  hs = {1'b0, a_ff[3:0]} + {1'b0, m_ff[3:0]} + {4'h0, cin};
                  f_in[FL_H] = hs[4];
                  f_in[FL_V] = (a_ff[7] ^ s9[7]) & (m_ff[7] ^ s9[7]);
                  f_in[FL_C] = s9[8];
                  f_in[FL_N] = s9[7]; f_in[FL_Z] = (s9[7:0] == 8'h00);
                  a_in = s9[7:0];
               end
               FN_SUB, FN_SBC, FN_CMP, FN_CPX: begin
                  src = (fn_ff == FN_CPX) ? x_ff : a_ff;
                  cin = (fn_ff == FN_SBC) && f_ff[FL_C];
                  s9 = {1'b0, src} - {1'b0, m_ff} - {8'h00, cin};
                  f_in[FL_C] = s9[8];
                  f_in[FL_V] = (src[7] ^ m_ff[7]) & (src[7] ^ s9[7]);
                  f_in[FL_N] = s9[7]; f_in[FL_Z] = (s9[7:0] == 8'h00);
                  if (fn_ff == FN_SUB || fn_ff == FN_SBC) a_in = s9[7:0];
               end
               FN_AND, FN_BIT, FN_ORA, FN_EOR: begin
                  if (fn_ff == FN_ORA) r8 = a_ff | m_ff;
                  else if (fn_ff == FN_EOR) r8 = a_ff ^ m_ff;
                  else r8 = a_ff & m_ff;
                  f_in[FL_V] = 1'b0; f_in[FL_N] = r8[7]; f_in[FL_Z] = (r8 == 8'h00);
                  if (fn_ff != FN_BIT) a_in = r8;
               end
               FN_LDA, FN_LDX, FN_STA, FN_STX: begin
                  if (fn_ff == FN_LDA) begin a_in = m_ff; r8 = m_ff; end
                  else if (fn_ff == FN_LDX) begin x_in = m_ff; r8 = m_ff; end
                  else begin
                     r8 = (fn_ff == FN_STA) ? a_ff : x_ff;
                     wd_in = r8; we_in = 1'b1;
                  end
                  f_in[FL_V] = 1'b0; f_in[FL_N] = r8[7]; f_in[FL_Z] = (r8 == 8'h00);
               end
               FN_ASR, FN_LSR, FN_ROR, FN_LSL, FN_ROL, FN_INC, FN_DEC, FN_NEG,
               FN_COM, FN_CLR, FN_DBNZ: begin
                  case (fn_ff)
                     FN_ASR: begin sh_c = src[0]; r8 = {src[7], src[7:1]}; end
                     FN_LSR: begin sh_c = src[0]; r8 = {1'b0, src[7:1]}; end
                     FN_ROR: begin sh_c = src[0]; r8 = {f_ff[FL_C], src[7:1]}; end
                     FN_LSL: begin sh_c = src[7]; r8 = {src[6:0], 1'b0}; end
                     FN_ROL: begin sh_c = src[7]; r8 = {src[6:0], f_ff[FL_C]}; end
                     FN_INC: r8 = src + 8'd1;
                     FN_DEC, FN_DBNZ: r8 = src - 8'd1;
                     FN_NEG: r8 = 8'h00 - src;
                     FN_COM: r8 = ~src;
                     default: r8 = 8'h00;
                  endcase
                  if (fn_ff <= FN_ROL) begin
                     f_in[FL_C] = sh_c; f_in[FL_V] = r8[7] ^ sh_c;
                  end else if (fn_ff == FN_INC) f_in[FL_V] = (r8 == 8'h80);
                  else if (fn_ff == FN_DEC) f_in[FL_V] = (r8 == 8'h7F);
                  else if (fn_ff == FN_NEG) begin
                     f_in[FL_C] = (r8 != 8'h00); f_in[FL_V] = (r8 == 8'h80);
                  end else if (fn_ff == FN_COM) begin
                     f_in[FL_C] = 1'b1; f_in[FL_V] = 1'b0;
                  end else if (fn_ff == FN_CLR) f_in[FL_V] = 1'b0;
                  if (fn_ff != FN_DBNZ) begin
                     f_in[FL_N] = r8[7]; f_in[FL_Z] = (r8 == 8'h00);
                  end else br_in = (r8 != 8'h00);
                  case (tg_ff)
                     TGT_A:   a_in = r8;
                     TGT_X:   x_in = r8;
                     TGT_H:   h_in = r8;
                     default: begin wd_in = r8; we_in = 1'b1; end
                  endcase
               end
               FN_TST: begin
                  f_in[FL_V] = 1'b0; f_in[FL_N] = src[7]; f_in[FL_Z] = (src == 8'h00);
               end
               FN_DAA: begin
                  if (f_ff[FL_H] || lo4 > 4'd9) fix[3:0] = 4'h6;
                  if (f_ff[FL_C] || hi4 > 4'd9 || (hi4 >= 4'd9 && lo4 > 4'd9)) begin
                     fix[7:4] = 4'h6; cu = 1'b1;
                  end
                  r8 = a_ff + fix;
                  f_in[FL_C] = cu; f_in[FL_N] = r8[7]; f_in[FL_Z] = (r8 == 8'h00);
                  a_in = r8;
               end
               FN_MUL: begin
                  cmd.start = 1'b1; cmd.is_mul = 1'b1;
                  cmd.dividend = {8'h00, x_ff}; cmd.divisor = a_ff;
                  state_in = ST_WAIT; out_v_in = 1'b0;
               end
               FN_DIV: begin
                  if (x_ff == 8'h00) f_in[FL_C] = 1'b1;
                  else begin
                     cmd.start = 1'b1; state_in = ST_WAIT; out_v_in = 1'b0;
                  end
               end
               FN_NSA: a_in = {a_ff[3:0], a_ff[7:4]};
               FN_TAX: x_in = a_ff;
               FN_TXA: a_in = x_ff;
               FN_TAP: f_in = a_ff;
               FN_TPA: a_in = f_ff;
               FN_CLC: f_in[FL_C] = 1'b0;
               FN_SEC: f_in[FL_C] = 1'b1;
               FN_CLI: f_in[FL_I] = 1'b0;
               FN_SEI: f_in[FL_I] = 1'b1;
               FN_CPHX: begin
                  f_in[FL_C] = (mw > hx);
                  f_in[FL_V] = (hx[15] ^ mw[15]) & (hx[15] ^ t16[15]);
                  f_in[FL_N] = t16[15]; f_in[FL_Z] = (t16 == 16'h0000);
               end
               FN_LDHX: begin
                  h_in = mh_ff; x_in = m_ff; f_in[FL_V] = 1'b0;
                  f_in[FL_N] = mh_ff[7]; f_in[FL_Z] = ((mh_ff | m_ff) == 8'h00);
               end
               FN_BSET: begin wd_in = m_ff | (8'h01 << bi_ff); we_in = 1'b1; end
               FN_BCLR: begin wd_in = m_ff & ~(8'h01 << bi_ff); we_in = 1'b1; end
               FN_BRSET, FN_BRCLR: begin
                  cr = m_ff[bi_ff];
                  f_in[FL_C] = cr;
                  br_in = (fn_ff == FN_BRSET) ? cr : !cr;
               end
               FN_CBEQ: br_in = (((tg_ff == TGT_X) ? x_ff : a_ff) == m_ff);
               FN_BCC: br_in = cond_eval(cn_ff, f_ff, irq_ff);
               FN_MOV: begin
                  wd_in = m_ff; we_in = 1'b1; f_in[FL_V] = 1'b0;
                  f_in[FL_N] = m_ff[7]; f_in[FL_Z] = (m_ff == 8'h00);
               end
               default: ;
            endcase
            f_in = f_in & FLAG_MASK;
         end
         ST_WAIT: begin
            if (res.done) begin
               state_in = ST_IDLE; out_v_in = 1'b1;
               if (fn_ff == FN_MUL) begin
                  x_in = res.rem; a_in = res.quot[15:8];
                  f_in[FL_H] = 1'b0; f_in[FL_C] = 1'b0;
               end else begin
                  a_in = res.quot[7:0]; h_in = res.rem;
                  f_in[FL_C] = (res.quot[15:8] != 8'h00);
                  f_in[FL_Z] = (res.quot == 16'h0000);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         a_ff <= 8'h00; h_ff <= 8'h00; x_ff <= 8'h00; f_ff <= FLAG_RESET;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         a_ff <= a_in; h_ff <= h_in; x_ff <= x_in; f_ff <= f_in;
      end
      wd_ff <= wd_in; we_ff <= we_in; br_ff <= br_in;
      if (accept) begin
         fn_ff <= req_func; m_ff <= req_operand; mh_ff <= req_operand_high;
         tg_ff <= req_target; bi_ff <= req_bit_index; cn_ff <= req_condition;
         irq_ff <= req_irq_level;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_write_data     = wd_ff;
   assign rsp_write_enable   = we_ff;
   assign rsp_branch_taken   = br_ff;
   assign rsp_acc_out        = a_ff;
   assign rsp_index_high_out = h_ff;
   assign rsp_index_low_out  = x_ff;
   assign rsp_flags_out      = f_ff;
endmodule
`default_nettype wire

/* design/mcu8_checker.sv */
// Port-level checker for the ALU core, bound to the top level.
`default_nettype none
module mcu8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_write_enable,
   input wire logic [7:0] rsp_write_data,
   input wire logic [7:0] rsp_flags_out
);
   a_flags_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flags_out[6:5] == 2'b00) else $error("unused flag bits set");
   a_wd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_data == 8'h00)
      else $error("write data without enable");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

bind mcu8_alu_with_condition_codes_core mcu8_checker u_mcu8_checker (.*);
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the 8-bit accumulator ALU core with condition codes.
module testbench
   import mcu8_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // one operation sent to the core
   typedef struct packed {
      logic [5:0] func;
      logic [7:0] operand;
      logic [7:0] operand_high;
      logic [1:0] target;
      logic [2:0] bit_index;
      logic [4:0] condition;
      logic       irq_level;
   } op_type;

   // architectural state and outputs after one operation
   typedef struct packed {
      logic [7:0] write_data;
      logic       write_enable;
      logic       branch_taken;
      logic [7:0] acc;
      logic [7:0] idx_high;
      logic [7:0] idx_low;
      logic [7:0] ccr;
   } outcome_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic       clock, reset;
   logic       req_valid, req_ready;
   logic [5:0] req_func;
   logic [7:0] req_operand, req_operand_high;
   logic [1:0] req_target;
   logic [2:0] req_bit_index;
   logic [4:0] req_condition;
   logic       req_irq_level;
   logic       rsp_valid, rsp_ready;
   logic [7:0] rsp_write_data;
   logic       rsp_write_enable, rsp_branch_taken;
   logic [7:0] rsp_acc_out, rsp_index_high_out, rsp_index_low_out, rsp_flags_out;

   mcu8_alu_with_condition_codes_core dut (.*);

   op_type      pending_ops[$];
   outcome_type expected_outcomes[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 9, recv_idle_pct = 80;
   bit          stimulus_done = 0;

   // predictor copy of the programmer-visible registers
   logic [7:0] p_acc, p_h, p_x, p_ccr;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic logic branch_holds(input logic [4:0] c, input logic irq);
      logic r;
      logic fc, fz, fn, fv, fh, fi;
      fc = p_ccr[FL_C]; fz = p_ccr[FL_Z]; fn = p_ccr[FL_N];
      fv = p_ccr[FL_V]; fh = p_ccr[FL_H]; fi = p_ccr[FL_I];
      case (c[4:1])
         4'd0: r = 1'b1;
         4'd1: r = !(fc || fz);
         4'd2: r = !fc;
         4'd3: r = !fz;
         4'd4: r = !fh;
         4'd5: r = !fn;
         4'd6: r = !fi;
         4'd7: r = (irq == 1'b0);
         4'd8: r = !(fn ^ fv);
         4'd9: r = !(fz || (fn ^ fv));
         default: return 1'b0;
      endcase
      return c[0] ? !r : r;
   endfunction

   // computes the outcome of one operation and advances the predictor state
   function automatic outcome_type execute_op(input op_type op);
      outcome_type o;
      logic [8:0]  sum;
      logic [7:0]  r, src, m, f;
      logic        cin, cu, bitv;
      logic [15:0] d, q, hx, mw, t;
      o = '0;
      m = op.operand;
      case (op.target)
         TGT_A: src = p_acc;
         TGT_X: src = p_x;
         TGT_H: src = p_h;
         default: src = m;
      endcase
      r = 8'h00;
      case (op.func)
         FN_ADD, FN_ADC: begin
            cin = (op.func == FN_ADC) && p_ccr[FL_C];
            sum = p_acc + m + cin;
            p_ccr[FL_H] = ({1'b0, p_acc[3:0]} + m[3:0] + cin) > 5'd15;
            p_ccr[FL_V] = ((p_acc ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 0;
            p_ccr[FL_C] = sum[8];
            r = sum[7:0];
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
            p_acc = r;
         end
         FN_SUB, FN_SBC, FN_CMP, FN_CPX: begin
            src = (op.func == FN_CPX) ? p_x : p_acc;
            cin = (op.func == FN_SBC) && p_ccr[FL_C];
            r = src - m - cin;
            p_ccr[FL_C] = ({1'b0, m} + cin) > {1'b0, src};
            p_ccr[FL_V] = ((src ^ m) & (src ^ r) & 8'h80) != 0;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
            if (op.func == FN_SUB || op.func == FN_SBC) p_acc = r;
         end
         FN_AND, FN_BIT, FN_ORA, FN_EOR: begin
            r = (op.func == FN_ORA) ? (p_acc | m) :
                (op.func == FN_EOR) ? (p_acc ^ m) : (p_acc & m);
            p_ccr[FL_V] = 0;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
            if (op.func != FN_BIT) p_acc = r;
         end
         FN_LDA, FN_LDX, FN_STA, FN_STX: begin
            if (op.func == FN_LDA) begin p_acc = m; r = m; end
            else if (op.func == FN_LDX) begin p_x = m; r = m; end
            else begin
               r = (op.func == FN_STA) ? p_acc : p_x;
               o.write_data = r; o.write_enable = 1;
            end
            p_ccr[FL_V] = 0;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
         end
         FN_ASR, FN_LSR, FN_ROR, FN_LSL, FN_ROL: begin
            if (op.func <= FN_ROR) begin
               cin = src[0];
               r = src >> 1;
               if (op.func == FN_ASR) r[7] = src[7];
               if (op.func == FN_ROR) r[7] = p_ccr[FL_C];
            end else begin
               cin = src[7];
               r = src << 1;
               if (op.func == FN_ROL) r[0] = p_ccr[FL_C];
            end
            p_ccr[FL_C] = cin;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
            p_ccr[FL_V] = r[7] ^ cin;
         end
         FN_INC, FN_DEC: begin
            r = (op.func == FN_INC) ? src + 1 : src - 1;
            p_ccr[FL_V] = (op.func == FN_INC) ? (r == 8'h80) : (r == 8'h7F);
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
         end
         FN_NEG: begin
            r = 8'h00 - src;
            p_ccr[FL_C] = (r != 0);
            p_ccr[FL_V] = (r == 8'h80);
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
         end
         FN_COM: begin
            r = ~src;
            p_ccr[FL_C] = 1; p_ccr[FL_V] = 0;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
         end
         FN_CLR: begin
            r = 0;
            p_ccr[FL_V] = 0; p_ccr[FL_N] = 0; p_ccr[FL_Z] = 1;
         end
         FN_TST: begin
            p_ccr[FL_V] = 0;
            p_ccr[FL_N] = src[7]; p_ccr[FL_Z] = (src == 0);
         end
         FN_DAA: begin
            // correction comes from A as it stood before the adjust
            f = 8'h00; cu = 0;
            if (p_ccr[FL_H] || p_acc[3:0] > 9) f = f | 8'h06;
            if (p_ccr[FL_C] || p_acc[7:4] > 9 || (p_acc[7:4] >= 9 && p_acc[3:0] > 9)) begin
               f = f | 8'h60; cu = 1;
            end
            r = p_acc + f;
            p_ccr[FL_C] = cu;
            p_ccr[FL_N] = r[7]; p_ccr[FL_Z] = (r == 0);
            p_acc = r;
         end
         FN_MUL: begin
            d = p_acc * p_x;
            p_x = d[15:8]; p_acc = d[7:0];
            p_ccr[FL_H] = 0; p_ccr[FL_C] = 0;
         end
         FN_DIV: begin
            if (p_x == 0) p_ccr[FL_C] = 1;
            else begin
               d = {p_h, p_acc};
               q = d / p_x;
               p_ccr[FL_C] = (q > 16'h00FF);
               p_ccr[FL_Z] = (q == 0);
               p_h = d % p_x;
               p_acc = q[7:0];
            end
         end
         FN_NSA: p_acc = {p_acc[3:0], p_acc[7:4]};
         FN_TAX: p_x = p_acc;
         FN_TXA: p_acc = p_x;
         FN_TAP: p_ccr = p_acc;
         FN_TPA: p_acc = p_ccr;
         FN_CLC: p_ccr[FL_C] = 0;
         FN_SEC: p_ccr[FL_C] = 1;
         FN_CLI: p_ccr[FL_I] = 0;
         FN_SEI: p_ccr[FL_I] = 1;
         FN_CPHX: begin
            hx = {p_h, p_x};
            mw = {op.operand_high, m};
            t = hx - mw;
            p_ccr[FL_C] = (mw > hx);
            p_ccr[FL_V] = ((hx ^ mw) & (hx ^ t) & 16'h8000) != 0;
            p_ccr[FL_N] = t[15];
            p_ccr[FL_Z] = (t == 0);
         end
         FN_LDHX: begin
            p_h = op.operand_high; p_x = m;
            p_ccr[FL_V] = 0;
            p_ccr[FL_N] = op.operand_high[7];
            p_ccr[FL_Z] = ({op.operand_high, m} == 0);
         end
         FN_BSET: begin o.write_data = m | (8'h01 << op.bit_index); o.write_enable = 1; end
         FN_BCLR: begin o.write_data = m & ~(8'h01 << op.bit_index); o.write_enable = 1; end
         FN_BRSET, FN_BRCLR: begin
            bitv = m[op.bit_index];
            p_ccr[FL_C] = bitv;
            o.branch_taken = (op.func == FN_BRSET) ? bitv : !bitv;
         end
         FN_CBEQ: o.branch_taken = (((op.target == TGT_X) ? p_x : p_acc) == m);
         FN_DBNZ: begin
            r = src - 1;
            o.branch_taken = (r != 0);
         end
         FN_BCC: o.branch_taken = branch_holds(op.condition, op.irq_level);
         FN_MOV: begin
            o.write_data = m; o.write_enable = 1;
            p_ccr[FL_V] = 0;
            p_ccr[FL_N] = m[7]; p_ccr[FL_Z] = (m == 0);
         end
         default: ;
      endcase
      // read-modify-write write-back (TST only reads)
      if ((op.func >= FN_ASR && op.func <= FN_CLR) || op.func == FN_DBNZ) begin
         case (op.target)
            TGT_A: p_acc = r;
            TGT_X: p_x = r;
            TGT_H: p_h = r;
            default: begin o.write_data = r; o.write_enable = 1; end
         endcase
      end
      p_ccr = p_ccr & FLAG_MASK;
      o.acc = p_acc; o.idx_high = p_h; o.idx_low = p_x; o.ccr = p_ccr;
      return o;
   endfunction

   function automatic op_type random_op();
      op_type op;
      op = $urandom;
      // mostly defined selectors, some unused ones as well
      op.func = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 47);
      if ($urandom_range(0, 3) == 0)
         op.operand = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 3) == 0)
         op.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      if ($urandom_range(0, 7) == 0) op.operand = 8'h80;
      return op;
   endfunction

   function automatic op_type make_op(input logic [5:0] fn, input logic [7:0] m,
                                      input logic [1:0] tgt);
      op_type op;
      op = '0;
      op.func = fn; op.operand = m; op.target = tgt;
      return op;
   endfunction

   // driver: valid held with stable payload until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            op_type op;
            op = pending_ops.pop_front();
            expected_outcomes.push_back(execute_op(op));
            req_valid <= 1;
            {req_func, req_operand, req_operand_high, req_target, req_bit_index,
             req_condition, req_irq_level} <= op;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         outcome_type got, want;
         got = {rsp_write_data, rsp_write_enable, rsp_branch_taken, rsp_acc_out,
                rsp_index_high_out, rsp_index_low_out, rsp_flags_out};
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got.write_data !== want.write_data) begin
               $display("%0t: write_data expected %h actual %h", $time, want.write_data,
                        got.write_data); errors++; end
            if (got.write_enable !== want.write_enable) begin
               $display("%0t: write_enable expected %b actual %b", $time, want.write_enable,
                        got.write_enable); errors++; end
            if (got.branch_taken !== want.branch_taken) begin
               $display("%0t: branch_taken expected %b actual %b", $time, want.branch_taken,
                        got.branch_taken); errors++; end
            if (got.acc !== want.acc) begin
               $display("%0t: acc_out expected %h actual %h", $time, want.acc, got.acc);
               errors++; end
            if (got.idx_high !== want.idx_high) begin
               $display("%0t: index_high_out expected %h actual %h", $time, want.idx_high,
                        got.idx_high); errors++; end
            if (got.idx_low !== want.idx_low) begin
               $display("%0t: index_low_out expected %h actual %h", $time, want.idx_low,
                        got.idx_low); errors++; end
            if (got.ccr !== want.ccr) begin
               $display("%0t: flags_out expected %h actual %h", $time, want.ccr, got.ccr);
               errors++; end
         end
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("mcu8_alu_with_condition_codes_core regression: fail");
         $finish;
      end
   end

   initial begin
      int k;
      req_valid = 0; req_func = 0; req_operand = 0; req_operand_high = 0;
      req_target = 0; req_bit_index = 0; req_condition = 0; req_irq_level = 0;
      rsp_ready = 0;
      p_acc = 0; p_h = 0; p_x = 0; p_ccr = FLAG_RESET;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: extremes, divide by zero, divide overflow, DAA on bad BCD,
      // register targets, TAP clearing the flags, a never-taken and an IRQ-level condition
      pending_ops.push_back(make_op(FN_LDA, 8'hFF, TGT_MEM));
      pending_ops.push_back(make_op(FN_ADD, 8'h01, TGT_MEM));
      pending_ops.push_back(make_op(FN_SBC, 8'hFF, TGT_MEM));
      pending_ops.push_back(make_op(FN_TAP, 8'h00, TGT_MEM)); // A=00 here, so all flags clear
      pending_ops.push_back(make_op(FN_TPA, 8'h00, TGT_MEM));
      pending_ops.push_back(make_op(FN_LDX, 8'h00, TGT_MEM));
      pending_ops.push_back(make_op(FN_DIV, 8'h00, TGT_MEM)); // divide by zero
      pending_ops.push_back(make_op(FN_LDX, 8'h01, TGT_MEM));
      pending_ops.push_back(make_op(FN_INC, 8'h7F, TGT_H));
      pending_ops.push_back(make_op(FN_DIV, 8'h00, TGT_MEM)); // quotient overflow
      pending_ops.push_back(make_op(FN_LDA, 8'hAF, TGT_MEM));
      pending_ops.push_back(make_op(FN_DAA, 8'h00, TGT_MEM)); // invalid BCD digits
      pending_ops.push_back(make_op(FN_MUL, 8'h00, TGT_MEM));
      pending_ops.push_back(make_op(FN_NEG, 8'h80, TGT_MEM));
      pending_ops.push_back(make_op(FN_DEC, 8'h80, TGT_X));
      pending_ops.push_back(make_op(FN_ROR, 8'h01, TGT_A));
      pending_ops.push_back(make_op(FN_TST, 8'h00, TGT_MEM));
      pending_ops.push_back(make_op(FN_DBNZ, 8'h01, TGT_MEM));
      pending_ops.push_back(make_op(FN_CBEQ, 8'h7F, TGT_X));
      pending_ops.push_back(make_op(6'd63, 8'hFF, TGT_MEM)); // unused selector
      begin
         op_type op;
         op = make_op(FN_LDHX, 8'hFF, TGT_MEM); op.operand_high = 8'hFF;
         pending_ops.push_back(op);
         op = make_op(FN_CPHX, 8'h00, TGT_MEM); op.operand_high = 8'h80;
         pending_ops.push_back(op);
         op = make_op(FN_BRSET, 8'h80, TGT_MEM); op.bit_index = 3'd7;
         pending_ops.push_back(op);
         op = make_op(FN_BCC, 8'h00, TGT_MEM); op.condition = 5'd31; op.irq_level = 1;
         pending_ops.push_back(op);
         op = make_op(FN_BCC, 8'h00, TGT_MEM); op.condition = 5'd15; op.irq_level = 1;
         pending_ops.push_back(op);
      end

      // random, three idle phases
      for (k = 0; k < 3; k++) begin
         int n;
         n = (k == 2) ? 550 : 550;
         repeat (n) pending_ops.push_back(random_op());
         wait (pending_ops.size() == 0 && expected_outcomes.size() == 0);
         if (k == 0) begin send_idle_pct = 80; recv_idle_pct = 9; end
         else if (k == 1) begin send_idle_pct = 0; recv_idle_pct = 0; end
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("mcu8_alu_with_condition_codes_core regression: pass");
      else
         $display("mcu8_alu_with_condition_codes_core regression: fail");
      $finish;
   end
endmodule

/* sim.f */
design/mcu8_pkg.sv
design/mcu8_iter.sv
design/mcu8_alu_with_condition_codes_core.sv
design/mcu8_checker.sv
sim/testbench.sv
